@@ rtl/box_average_downscaler_macros.svh @@
// assertion macros for the box average downscaler rtl
// no dependencies; taken in by `include where a module asserts
`ifndef BOX_AVERAGE_DOWNSCALER_MACROS_SVH
`define BOX_AVERAGE_DOWNSCALER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define BOXDS_ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BOXDS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/boxds_pkg.sv @@
// shared types and fixed constants of the box average downscaler
// no dependencies; imported by every rtl module and by the channel interface users
`default_nettype none

package boxds_pkg;

   // fixed field widths
   localparam int CHAN_W      = 8;
   localparam int QUOT_W      = 8;
   localparam int RATIO_CFG_W = 5;
   localparam int SIDE_CFG_W  = 11;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 11;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_RATIO = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_SIDE  = 8'd1;

   // register values after reset
   localparam logic [RATIO_CFG_W-1:0] RATIO_RESET = 5'd1;
   localparam logic [SIDE_CFG_W-1:0]  SIDE_RESET  = 11'd1024;

   typedef struct packed {
      logic [CHAN_W-1:0] red_in;
      logic [CHAN_W-1:0] green_in;
      logic [CHAN_W-1:0] blue_in;
   } pixel_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red_out;
      logic [CHAN_W-1:0] green_out;
      logic [CHAN_W-1:0] blue_out;
      logic              row_end;
      logic              image_end;
   } result_type;

   typedef struct packed {
      logic [CSR_INDEX_W-1:0] reg_index;
      logic [CSR_DATA_W-1:0]  write_data;
   } csr_write_type;

   // where the current pixel sits relative to its block
   typedef struct packed {
      logic in_block;
      logic block_start;
      logic block_end;
      logic row_end;
      logic image_end;
   } pos_tag_type;

   typedef struct packed {
      logic row_end;
      logic image_end;
   } end_flags_type;

endpackage

`default_nettype wire

@@ rtl/boxds_chan_if.sv @@
// valid/ready channel carrying one payload per transfer
// payload type is set at instantiation, usually a struct from boxds_pkg
`default_nettype none

interface boxds_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/boxds_raster.sv @@
// configuration registers and raster position tracking
// depends on boxds_pkg
`default_nettype none

module boxds_raster import boxds_pkg::*; #(
   parameter int MAX_SIDE  = 1024,
   parameter int MAX_RATIO = 16,
   localparam int RAT_W  = $clog2(MAX_RATIO + 1),
   localparam int SIDE_W = $clog2(MAX_SIDE + 1),
   localparam int ADDR_W = $clog2(MAX_SIDE),
   localparam int AREA_W = $clog2(MAX_RATIO * MAX_RATIO + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write,
   input  csr_write_type       csr_cmd,
   input  logic                advance,
   output logic [ADDR_W-1:0]   col_addr,
   output pos_tag_type         tag,
   output logic [AREA_W-1:0]   area
);

   localparam int CMP_W = (SIDE_W > RAT_W + 1) ? SIDE_W : RAT_W + 1;

   function automatic logic [RAT_W-1:0] clamp_ratio(input logic [RATIO_CFG_W-1:0] v);
      logic [RAT_W-1:0] r;
      if (v == '0) begin
         r = RAT_W'(1);
      end else if (int'(v) > MAX_RATIO) begin
         r = RAT_W'(MAX_RATIO);
      end else begin
         r = RAT_W'(v);
      end
      return r;
   endfunction

   function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_CFG_W-1:0] v);
      logic [SIDE_W-1:0] s;
      if (v == '0) begin
         s = SIDE_W'(1);
      end else if (int'(v) > MAX_SIDE) begin
         s = SIDE_W'(MAX_SIDE);
      end else begin
         s = SIDE_W'(v);
      end
      return s;
   endfunction

   logic [RAT_W-1:0]  ratio_ff, ratio_in;
   logic [SIDE_W-1:0] side_ff, side_in;
   logic [AREA_W-1:0] area_ff, area_in;
   logic [RAT_W-1:0]  col_phase_ff, row_phase_ff;
   logic [SIDE_W-1:0] rem_col_ff, rem_row_ff;
   logic [ADDR_W-1:0] out_col_ff;
   logic              col_ok_ff, col_last_ff, row_ok_ff, row_last_ff;

   logic              restart;
   logic [RAT_W-1:0]  ratio_m1;
   logic [CMP_W-1:0]  ratio_ext, two_ratio;
   logic              cur_col_ok, cur_col_last, cur_row_ok, cur_row_last;
   logic              col_wrap, row_wrap, col_end, row_end_last;

   // register writes; any known index restarts the image
   always_comb begin
      ratio_in = ratio_ff;
      side_in  = side_ff;
      restart  = 1'b0;
      if (csr_write && csr_cmd.reg_index == CSR_SCALE_RATIO) begin
         ratio_in = clamp_ratio(csr_cmd.write_data[RATIO_CFG_W-1:0]);
         restart  = 1'b1;
      end else if (csr_write && csr_cmd.reg_index == CSR_IMAGE_SIDE) begin
         side_in = clamp_side(csr_cmd.write_data[SIDE_CFG_W-1:0]);
         restart = 1'b1;
      end
      area_in = AREA_W'(ratio_in) * AREA_W'(ratio_in);
   end

   // block membership, taken fresh at the first pixel of a block and held after
   assign ratio_m1  = ratio_ff - RAT_W'(1);
   assign ratio_ext = CMP_W'(ratio_ff);
   assign two_ratio = CMP_W'({ratio_ff, 1'b0});

   assign cur_col_ok   = (col_phase_ff == '0) ? (CMP_W'(rem_col_ff) >= ratio_ext) : col_ok_ff;
   assign cur_col_last = (col_phase_ff == '0) ? (CMP_W'(rem_col_ff) < two_ratio) : col_last_ff;
   assign cur_row_ok   = (row_phase_ff == '0) ? (CMP_W'(rem_row_ff) >= ratio_ext) : row_ok_ff;
   assign cur_row_last = (row_phase_ff == '0) ? (CMP_W'(rem_row_ff) < two_ratio) : row_last_ff;

   assign col_wrap     = (col_phase_ff == ratio_m1);
   assign row_wrap     = (row_phase_ff == ratio_m1);
   assign col_end      = (rem_col_ff == SIDE_W'(1));
   assign row_end_last = (rem_row_ff == SIDE_W'(1));

   assign tag.in_block    = cur_col_ok & cur_row_ok;
   assign tag.block_start = (col_phase_ff == '0) & (row_phase_ff == '0);
   assign tag.block_end   = col_wrap & row_wrap;
   assign tag.row_end     = cur_col_last;
   assign tag.image_end   = cur_col_last & cur_row_last;
   assign col_addr        = out_col_ff;
   assign area            = area_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff <= clamp_ratio(RATIO_RESET);
         side_ff  <= clamp_side(SIDE_RESET);
         area_ff  <= AREA_W'(clamp_ratio(RATIO_RESET)) * AREA_W'(clamp_ratio(RATIO_RESET));
      end else begin
         ratio_ff <= ratio_in;
         side_ff  <= side_in;
         area_ff  <= area_in;
      end
   end

   // position counters count down the pixels left in the row and the rows left in the image
   always_ff @(posedge clock) begin
      if (reset || restart) begin
         col_phase_ff <= '0;
         row_phase_ff <= '0;
         rem_col_ff   <= reset ? clamp_side(SIDE_RESET) : side_in;
         rem_row_ff   <= reset ? clamp_side(SIDE_RESET) : side_in;
         out_col_ff   <= '0;
         col_ok_ff    <= 1'b0;
         col_last_ff  <= 1'b0;
         row_ok_ff    <= 1'b0;
         row_last_ff  <= 1'b0;
      end else if (advance) begin
         col_ok_ff   <= cur_col_ok;
         col_last_ff <= cur_col_last;
         row_ok_ff   <= cur_row_ok;
         row_last_ff <= cur_row_last;
         if (col_end) begin
            rem_col_ff   <= side_ff;
            col_phase_ff <= '0;
            out_col_ff   <= '0;
            if (row_end_last) begin
               rem_row_ff   <= side_ff;
               row_phase_ff <= '0;
            end else begin
               rem_row_ff   <= rem_row_ff - SIDE_W'(1);
               row_phase_ff <= row_wrap ? '0 : row_phase_ff + RAT_W'(1);
            end
         end else begin
            rem_col_ff   <= rem_col_ff - SIDE_W'(1);
            col_phase_ff <= col_wrap ? '0 : col_phase_ff + RAT_W'(1);
            out_col_ff   <= out_col_ff + ADDR_W'(col_wrap);
         end
      end
   end

endmodule

`default_nettype wire

@@ rtl/boxds_accum.sv @@
// column sum memory with read-modify-write and write-to-read forwarding
// depends on boxds_pkg
`default_nettype none

module boxds_accum import boxds_pkg::*; #(
   parameter int MAX_SIDE  = 1024,
   parameter int MAX_RATIO = 16,
   localparam int ADDR_W = $clog2(MAX_SIDE),
   localparam int SUM_W  = $clog2(MAX_RATIO * MAX_RATIO * 255 + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 take,
   input  logic [ADDR_W-1:0]    addr,
   input  pixel_type            pixel,
   input  pos_tag_type          tag,
   input  logic                 div_ready,
   output logic                 stall,
   output logic                 load_valid,
   output logic [3*SUM_W-1:0]   sums,
   output end_flags_type        flags
);

   logic [3*SUM_W-1:0] sum_mem [MAX_SIDE];
   logic [3*SUM_W-1:0] rd_data_ff;
   logic [3*SUM_W-1:0] wr_data_ff;

   logic               b_valid_ff;
   logic [ADDR_W-1:0]  b_addr_ff;
   pixel_type          b_pixel_ff;
   logic               b_start_ff;
   logic               b_emit_ff;
   logic               b_fwd_ff;
   end_flags_type      b_flags_ff;

   logic               fire;
   logic [3*SUM_W-1:0] old_word, new_word;
   logic [3*CHAN_W-1:0] pix_word;

   assign stall      = b_valid_ff & b_emit_ff & ~div_ready;
   assign fire       = b_valid_ff & ~stall;
   assign load_valid = b_valid_ff & b_emit_ff;
   assign sums       = new_word;
   assign flags      = b_flags_ff;

   // add the pixel to the old sum, or start fresh at a block's first pixel
   assign old_word = b_fwd_ff ? wr_data_ff : rd_data_ff;
   assign pix_word = {b_pixel_ff.red_in, b_pixel_ff.green_in, b_pixel_ff.blue_in};
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         new_word[ch*SUM_W +: SUM_W] =
            (b_start_ff ? '0 : old_word[ch*SUM_W +: SUM_W])
            + SUM_W'(pix_word[ch*CHAN_W +: CHAN_W]);
      end
   end

   // sum memory, one read and one write port
   always_ff @(posedge clock) begin
      if (fire) begin
         sum_mem[b_addr_ff] <= new_word;
      end
      if (take) begin
         rd_data_ff <= sum_mem[addr];
      end
   end

   // last written word, used when the read raced the write to the same entry
   always_ff @(posedge clock) begin
      if (fire) begin
         wr_data_ff <= new_word;
      end
   end

   // modify stage
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (take) begin
         b_valid_ff <= 1'b1;
      end else if (fire) begin
         b_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         b_addr_ff            <= addr;
         b_pixel_ff           <= pixel;
         b_start_ff           <= tag.block_start;
         b_emit_ff            <= tag.block_end;
         b_fwd_ff             <= fire && (b_addr_ff == addr);
         b_flags_ff.row_end   <= tag.row_end;
         b_flags_ff.image_end <= tag.image_end;
      end
   end

endmodule

`default_nettype wire

@@ rtl/boxds_divider.sv @@
// three channel bit-serial divider of block sums by the block area, with result register
// depends on boxds_pkg and box_average_downscaler_macros.svh
`default_nettype none
`include "box_average_downscaler_macros.svh"

module boxds_divider import boxds_pkg::*; #(
   parameter int MAX_RATIO = 16,
   localparam int SUM_W  = $clog2(MAX_RATIO * MAX_RATIO * 255 + 1),
   localparam int AREA_W = $clog2(MAX_RATIO * MAX_RATIO + 1),
   localparam int DVS_W  = AREA_W + QUOT_W - 1,
   localparam int CMP_W  = AREA_W + QUOT_W,
   localparam int STEP_W = $clog2(QUOT_W)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                load_valid,
   input  logic [3*SUM_W-1:0]  sums,
   input  logic [AREA_W-1:0]   area,
   input  end_flags_type       flags,
   output logic                ready,
   output logic                out_valid,
   input  logic                out_ready,
   output result_type          result
);

   typedef enum logic [2:0] {
      DIV_IDLE = 3'b001,
      DIV_RUN  = 3'b010,
      DIV_DONE = 3'b100
   } div_state_type;

   div_state_type      state_ff, state_in;
   logic [STEP_W-1:0]  step_ff;
   logic [SUM_W-1:0]   rem_ff [3];
   logic [QUOT_W-1:0]  quot_ff [3];
   logic [DVS_W-1:0]   dvs_ff;
   logic [AREA_W-1:0]  area_ff;
   end_flags_type      flags_ff;

   logic               take_job;
   logic               unit_area;
   logic [2:0]         ge;

   assign ready     = (state_ff == DIV_IDLE) | ((state_ff == DIV_DONE) & out_ready);
   assign take_job  = ready & load_valid;
   assign unit_area = (area == AREA_W'(1));
   assign out_valid = (state_ff == DIV_DONE);

   assign result.red_out   = quot_ff[2];
   assign result.green_out = quot_ff[1];
   assign result.blue_out  = quot_ff[0];
   assign result.row_end   = flags_ff.row_end;
   assign result.image_end = flags_ff.image_end;

   // trial subtraction of the shifted divisor, one quotient bit per cycle
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         ge[ch] = CMP_W'(rem_ff[ch]) >= CMP_W'(dvs_ff);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         DIV_IDLE: begin
            if (take_job) begin
               state_in = unit_area ? DIV_DONE : DIV_RUN;
            end
         end
         DIV_RUN: begin
            if (step_ff == '0) begin
               state_in = DIV_DONE;
            end
         end
         DIV_DONE: begin
            if (take_job) begin
               state_in = unit_area ? DIV_DONE : DIV_RUN;
            end else if (out_ready) begin
               state_in = DIV_IDLE;
            end
         end
         default: state_in = DIV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (take_job) begin
         area_ff  <= area;
         flags_ff <= flags;
         step_ff  <= STEP_W'(QUOT_W - 1);
         dvs_ff   <= DVS_W'(area) << (QUOT_W - 1);
         for (int ch = 0; ch < 3; ch++) begin
            if (unit_area) begin
               rem_ff[ch]  <= '0;
               quot_ff[ch] <= sums[ch*SUM_W +: QUOT_W];
            end else begin
               rem_ff[ch]  <= sums[ch*SUM_W +: SUM_W];
               quot_ff[ch] <= '0;
            end
         end
      end else if (state_ff == DIV_RUN) begin
         step_ff <= step_ff - STEP_W'(1);
         dvs_ff  <= dvs_ff >> 1;
         for (int ch = 0; ch < 3; ch++) begin
            if (ge[ch]) begin
               rem_ff[ch] <= SUM_W'(CMP_W'(rem_ff[ch]) - CMP_W'(dvs_ff));
            end
            quot_ff[ch] <= {quot_ff[ch][QUOT_W-2:0], ge[ch]};
         end
      end
   end

   // a finished division leaves every remainder below the divisor
   `BOXDS_ASSERT_HOLDS(div_rem_bound, clock, reset, state_ff == DIV_DONE, rem_ff[0] < area_ff && rem_ff[1] < area_ff && rem_ff[2] < area_ff, "remainder not below block area")
   // unit area bypasses the iteration
   `BOXDS_ASSERT_NEXT(div_unit_bypass, clock, reset, take_job && unit_area, state_ff == DIV_DONE, "unit area job did not finish at once")
   // other areas iterate
   `BOXDS_ASSERT_NEXT(div_start_run, clock, reset, take_job && !unit_area, state_ff == DIV_RUN && step_ff == STEP_W'(QUOT_W - 1), "division did not start iterating")
   // the last iteration hands over to the result register
   `BOXDS_ASSERT_NEXT(div_last_step, clock, reset, state_ff == DIV_RUN && step_ff == '0, state_ff == DIV_DONE, "division did not finish after last step")

endmodule

`default_nettype wire

@@ rtl/box_average_downscaler.sv @@
// top level of the box average downscaler
// depends on boxds_pkg, boxds_chan_if, boxds_raster, boxds_accum, boxds_divider
//
//   channel   role     payload                                   transfer when
//   req_if    sink     red_in, green_in, blue_in                 valid & ready
//   rsp_if    source   red_out, green_out, blue_out, row_end,    valid & ready
//                      image_end
//   csr_if    sink     reg_index, write_data                     valid & ready
//
// a pixel's column sum is read at its transfer edge and the updated sum is written back
// from the modify stage; a completed block then occupies the shared divider until taken.
// ratio 1 runs one pixel per cycle while rsp_if is ready; otherwise req_if stalls when a
// block ends before the previous division has been taken, so small ratios average about
// one pixel per cycle over rows outside the last row of a band. csr_if is always ready.
// reset needs no clearing pass: each block's sum restarts at its top-left pixel.
`default_nettype none

module box_average_downscaler import boxds_pkg::*; #(
   parameter int MAX_SIDE  = 1024,
   parameter int MAX_RATIO = 16
) (
   input  wire logic     clock,
   input  wire logic     reset,
   boxds_chan_if.sink    req_if,
   boxds_chan_if.source  rsp_if,
   boxds_chan_if.sink    csr_if
);

   localparam int ADDR_W = $clog2(MAX_SIDE);
   localparam int SUM_W  = $clog2(MAX_RATIO * MAX_RATIO * 255 + 1);
   localparam int AREA_W = $clog2(MAX_RATIO * MAX_RATIO + 1);

   logic               accept;
   logic               csr_write;
   logic [ADDR_W-1:0]  col_addr;
   pos_tag_type        tag;
   logic [AREA_W-1:0]  area;
   logic               stall;
   logic               load_valid;
   logic [3*SUM_W-1:0] sums;
   end_flags_type      flags;
   logic               div_ready;
   result_type         result;

   // handshakes
   assign csr_if.ready = 1'b1;
   assign csr_write    = csr_if.valid & csr_if.ready;
   assign req_if.ready = ~stall;
   assign accept       = req_if.valid & req_if.ready;
   assign rsp_if.data  = result;

   boxds_raster #(
      .MAX_SIDE  (MAX_SIDE),
      .MAX_RATIO (MAX_RATIO)
   ) u_raster (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_cmd   (csr_if.data),
      .advance   (accept),
      .col_addr  (col_addr),
      .tag       (tag),
      .area      (area)
   );

   boxds_accum #(
      .MAX_SIDE  (MAX_SIDE),
      .MAX_RATIO (MAX_RATIO)
   ) u_accum (
      .clock      (clock),
      .reset      (reset),
      .take       (accept & tag.in_block),
      .addr       (col_addr),
      .pixel      (req_if.data),
      .tag        (tag),
      .div_ready  (div_ready),
      .stall      (stall),
      .load_valid (load_valid),
      .sums       (sums),
      .flags      (flags)
   );

   boxds_divider #(
      .MAX_RATIO (MAX_RATIO)
   ) u_divider (
      .clock      (clock),
      .reset      (reset),
      .load_valid (load_valid),
      .sums       (sums),
      .area       (area),
      .flags      (flags),
      .ready      (div_ready),
      .out_valid  (rsp_if.valid),
      .out_ready  (rsp_if.ready),
      .result     (result)
   );

endmodule

`default_nettype wire

@@ sim/box_average_downscaler_test.sv @@
// self-checking testbench for box_average_downscaler: directed rows, then random images
// depends on boxds_pkg and boxds_chan_if from the rtl folder, plus the block itself
`timescale 1ns / 100ps

module box_average_downscaler_test import boxds_pkg::*; ();

   localparam int MAX_SIDE      = 1024;
   localparam int MAX_RATIO     = 16;
   localparam int CLOCK_PERIOD  = 4;
   localparam int RESET_CYCLES  = 11;
   localparam int SETTLE_CYCLES = 24;
   localparam int RANDOM_ITEMS  = 850;

   // register indexes outside the list
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOP_INDEX    = 8'hFF;

   typedef enum logic {ROW_WRITE, ROW_PIXEL} row_kind_type;
   typedef enum logic [1:0] {RSP_FLOW, RSP_COIN, RSP_SPARSE, RSP_LONG_STALL} rsp_pattern_type;

   typedef struct {
      row_kind_type           kind;
      logic [CSR_INDEX_W-1:0] reg_index;
      logic [CSR_DATA_W-1:0]  write_data;
      pixel_type              pixel;
      bit                     typed;
      bit                     has_result;
      result_type             result;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   boxds_chan_if #(.payload_type(pixel_type))     req_if ();
   boxds_chan_if #(.payload_type(result_type))    rsp_if ();
   boxds_chan_if #(.payload_type(csr_write_type)) csr_if ();

   box_average_downscaler #(
      .MAX_SIDE (MAX_SIDE),
      .MAX_RATIO(MAX_RATIO)
   ) uut (
      .clock (clock),
      .reset (reset),
      .req_if(req_if),
      .rsp_if(rsp_if),
      .csr_if(csr_if)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // model state: registers, per-column channel sums, raster position
   logic [RATIO_CFG_W-1:0] ratio_reg = RATIO_RESET;
   logic [SIDE_CFG_W-1:0]  side_reg  = SIDE_RESET;
   int unsigned red_acc [MAX_SIDE];
   int unsigned green_acc [MAX_SIDE];
   int unsigned blue_acc [MAX_SIDE];
   int unsigned col_pos = 0;
   int unsigned row_pos = 0;

   result_type   pending_averages [$];
   stim_row_type directed_rows [$];

   int error_count      = 0;
   int averages_seen    = 0;
   int pixels_sent      = 0;
   int directed_pixels  = 0;
   int settings_written = 0;
   int burst_left       = 0;

   rsp_pattern_type stall_mode = RSP_FLOW;
   int              stall_left = 0;

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      $display("%0t ns: result %0d %s: got %0h, want %0h",
               $time, averages_seen, what, got, want);
   endtask

   // queue an expected average at the tail
   function automatic void expect_average(input result_type res);
      pending_averages.insert(pending_averages.size(), res);
   endfunction

   // append one row to the directed table
   function automatic void add_row(input stim_row_type r);
      directed_rows.insert(directed_rows.size(), r);
   endfunction

   // one pixel through the box average: accumulate, emit the mean when a block completes
   task automatic box_average_step(input pixel_type p, output bit produced,
                                   output result_type res);
      int unsigned r, side, blocks, limit, col, row, oc, area;
      r      = (ratio_reg == 0) ? 1 : ((ratio_reg > MAX_RATIO) ? MAX_RATIO : ratio_reg);
      side   = (side_reg == 0) ? 1 : ((side_reg > MAX_SIDE) ? MAX_SIDE : side_reg);
      blocks = side / r;
      limit  = blocks * r;
      col    = (col_pos >= side) ? 0 : col_pos;
      row    = (row_pos >= side) ? 0 : row_pos;
      produced = 1'b0;
      res      = '0;
      if (col < limit && row < limit) begin
         oc = col / r;
         red_acc[oc]   += p.red_in;
         green_acc[oc] += p.green_in;
         blue_acc[oc]  += p.blue_in;
         if (col % r == r - 1 && row % r == r - 1) begin
            area          = r * r;
            res.red_out   = QUOT_W'(red_acc[oc] / area);
            res.green_out = QUOT_W'(green_acc[oc] / area);
            res.blue_out  = QUOT_W'(blue_acc[oc] / area);
            res.row_end   = (oc == blocks - 1);
            res.image_end = res.row_end && (row / r == blocks - 1);
            red_acc[oc]   = 0;
            green_acc[oc] = 0;
            blue_acc[oc]  = 0;
            produced      = 1'b1;
         end
      end
      // raster advance with wrap at the end of the image
      col++;
      if (col >= side) begin
         col = 0;
         row++;
         if (row >= side) row = 0;
      end
      col_pos = col;
      row_pos = row;
   endtask

   // hold the sender off until every pending average has been taken
   task automatic pause_until_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_averages.size() != 0) @(posedge clock);
   endtask

   // one pixel transfer; bursts of random length separated by random gaps
   task automatic send_pixel(input pixel_type p);
      if (burst_left == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 16);
      end
      burst_left--;
      req_if.valid <= 1'b1;
      req_if.data  <= p;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      pixels_sent++;
   endtask

   task automatic feed_pixel(input pixel_type p);
      bit         produced;
      result_type res;
      send_pixel(p);
      box_average_step(p, produced, res);
      if (produced) expect_average(res);
   endtask

   // register write once the block is idle; any listed register restarts the image
   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      pause_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.data  <= '{reg_index: idx, write_data: value};
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid <= 1'b0;
      settings_written++;
      if (idx == CSR_SCALE_RATIO || idx == CSR_IMAGE_SIDE) begin
         if (idx == CSR_SCALE_RATIO) ratio_reg = value[RATIO_CFG_W-1:0];
         else side_reg = value[SIDE_CFG_W-1:0];
         foreach (red_acc[k]) begin
            red_acc[k]   = 0;
            green_acc[k] = 0;
            blue_acc[k]  = 0;
         end
         col_pos = 0;
         row_pos = 0;
      end
   endtask

   function automatic stim_row_type write_row(input logic [CSR_INDEX_W-1:0] idx,
                                              input logic [CSR_DATA_W-1:0] value);
      stim_row_type row;
      row            = '{kind: ROW_WRITE, default: '0};
      row.reg_index  = idx;
      row.write_data = value;
      return row;
   endfunction

   function automatic stim_row_type pixel_row(input pixel_type p, input bit typed,
                                              input bit has_result, input result_type want);
      stim_row_type row;
      row            = '{kind: ROW_PIXEL, default: '0};
      row.pixel      = p;
      row.typed      = typed;
      row.has_result = has_result;
      row.result     = want;
      return row;
   endfunction

   function automatic logic [CHAN_W-1:0] random_channel();
      if ($urandom_range(0, 9) == 0) return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      return CHAN_W'($urandom_range(0, 255));
   endfunction

   // result side: check each transfer, then pick the next ready level
   always @(posedge clock) begin : result_side
      result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         averages_seen++;
         if (pending_averages.size() == 0) begin
            report_mismatch("arrived with nothing pending", 1, 0);
         end else begin
            want = pending_averages.pop_front();
            if (rsp_if.data.red_out != want.red_out)
               report_mismatch("red_out", rsp_if.data.red_out, want.red_out);
            if (rsp_if.data.green_out != want.green_out)
               report_mismatch("green_out", rsp_if.data.green_out, want.green_out);
            if (rsp_if.data.blue_out != want.blue_out)
               report_mismatch("blue_out", rsp_if.data.blue_out, want.blue_out);
            if (rsp_if.data.row_end != want.row_end)
               report_mismatch("row_end", rsp_if.data.row_end, want.row_end);
            if (rsp_if.data.image_end != want.image_end)
               report_mismatch("image_end", rsp_if.data.image_end, want.image_end);
         end
      end
      if (stall_left == 0) begin
         stall_mode = rsp_pattern_type'($urandom_range(0, 3));
         stall_left = $urandom_range(8, 64);
      end
      stall_left--;
      case (stall_mode)
         RSP_FLOW:   rsp_if.ready <= 1'b1;
         RSP_COIN:   rsp_if.ready <= ($urandom_range(0, 1) != 0);
         RSP_SPARSE: rsp_if.ready <= ($urandom_range(0, 3) == 0);
         default:    rsp_if.ready <= (stall_left % 12 == 0);
      endcase
   end

   // stimulus: directed rows, then random images at random settings
   initial begin : stimulus
      stim_row_type row;
      bit           produced;
      result_type   res;
      int           random_items, pick, ratio_val, side_val, r_eff, s_eff, count, hi;
      bit           forced_pause;

      req_if.valid <= 1'b0;
      req_if.data  <= '0;
      csr_if.valid <= 1'b0;
      csr_if.data  <= '0;

      // after reset: ratio 1 over a full-width image, so each pixel comes straight back
      add_row(pixel_row({8'h00, 8'h00, 8'h00}, 1, 1, {8'h00, 8'h00, 8'h00, 2'b00}));
      add_row(pixel_row({8'hFF, 8'hFF, 8'hFF}, 1, 1, {8'hFF, 8'hFF, 8'hFF, 2'b00}));
      add_row(pixel_row({8'h80, 8'h7F, 8'h01}, 1, 1, {8'h80, 8'h7F, 8'h01, 2'b00}));
      add_row(pixel_row({8'h55, 8'hAA, 8'hFF}, 1, 1, {8'h55, 8'hAA, 8'hFF, 2'b00}));
      // side zero acts as one: every pixel ends its row and the image, then wraps
      add_row(write_row(CSR_IMAGE_SIDE, 11'd0));
      add_row(pixel_row({8'hA5, 8'h5A, 8'h3C}, 1, 1, {8'hA5, 8'h5A, 8'h3C, 2'b11}));
      add_row(pixel_row({8'h01, 8'h02, 8'h03}, 1, 1, {8'h01, 8'h02, 8'h03, 2'b11}));
      // ratio zero acts as one
      add_row(write_row(CSR_SCALE_RATIO, 11'd0));
      add_row(pixel_row({8'hFF, 8'h00, 8'hFF}, 1, 1, {8'hFF, 8'h00, 8'hFF, 2'b11}));
      // 2x2 block with truncating division
      add_row(write_row(CSR_SCALE_RATIO, 11'd2));
      add_row(write_row(CSR_IMAGE_SIDE, 11'd2));
      add_row(pixel_row({8'hFF, 8'h00, 8'h01}, 1, 0, '0));
      add_row(pixel_row({8'hFF, 8'h00, 8'h02}, 1, 0, '0));
      add_row(pixel_row({8'hFF, 8'h00, 8'h03}, 1, 0, '0));
      add_row(pixel_row({8'hFF, 8'h03, 8'hFF}, 1, 1, {8'hFF, 8'h00, 8'h41, 2'b11}));
      // ratio larger than the side: pixels are taken, nothing comes out
      add_row(write_row(CSR_SCALE_RATIO, 11'd5));
      add_row(pixel_row({8'h12, 8'h34, 8'h56}, 1, 0, '0));
      add_row(pixel_row({8'h9A, 8'hBC, 8'hDE}, 1, 0, '0));
      // writes to unlisted indexes must not restart the block in mid-image
      add_row(write_row(CSR_SCALE_RATIO, 11'd2));
      add_row(pixel_row({8'h10, 8'h20, 8'h30}, 0, 0, '0));
      add_row(pixel_row({8'h11, 8'h21, 8'h31}, 0, 0, '0));
      add_row(write_row(CSR_UNUSED_INDEX, 11'd3));
      add_row(write_row(CSR_TOP_INDEX, 11'h7FF));
      add_row(pixel_row({8'h12, 8'h22, 8'h32}, 0, 0, '0));
      add_row(pixel_row({8'h13, 8'h23, 8'h33}, 0, 0, '0));
      // side above the maximum saturates to full width
      add_row(write_row(CSR_IMAGE_SIDE, 11'h7FF));
      add_row(write_row(CSR_SCALE_RATIO, 11'd1));
      add_row(pixel_row({8'hC3, 8'h3C, 8'h81}, 1, 1, {8'hC3, 8'h3C, 8'h81, 2'b00}));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_WRITE) begin
            write_register(row.reg_index, row.write_data);
         end else if (row.typed) begin
            send_pixel(row.pixel);
            box_average_step(row.pixel, produced, res);
            if (row.has_result) expect_average(row.result);
            directed_pixels++;
         end else begin
            feed_pixel(row.pixel);
            directed_pixels++;
         end
      end

      // first random image at a ratio above the maximum, one 16x16 block
      random_items = 0;
      write_register(CSR_SCALE_RATIO, 11'd31);
      write_register(CSR_IMAGE_SIDE, 11'd16);
      for (int i = 0; i < 260; i++) begin
         forced_pause = (i == 128);
         if (forced_pause || $urandom_range(0, 99) == 0) pause_until_drained();
         feed_pixel({random_channel(), random_channel(), random_channel()});
         random_items++;
      end

      while (random_items < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 80) ratio_val = $urandom_range(1, 5);
         else if (pick < 92) ratio_val = $urandom_range(6, 16);
         else if (pick < 96) ratio_val = 0;
         else ratio_val = $urandom_range(17, 31);
         r_eff = (ratio_val == 0) ? 1 : ((ratio_val > MAX_RATIO) ? MAX_RATIO : ratio_val);

         pick = $urandom_range(0, 99);
         if (pick < 8 && r_eff > 1) side_val = $urandom_range(1, r_eff - 1);
         else if (pick < 12) side_val = $urandom_range(0, 1);
         else begin
            hi = (r_eff * 4 < 24) ? 24 : r_eff * 2;
            side_val = $urandom_range(r_eff, hi);
         end
         s_eff = (side_val == 0) ? 1 : side_val;

         if ($urandom_range(0, 1) != 0) begin
            write_register(CSR_SCALE_RATIO, CSR_DATA_W'(ratio_val));
            write_register(CSR_IMAGE_SIDE, CSR_DATA_W'(side_val));
         end else begin
            write_register(CSR_IMAGE_SIDE, CSR_DATA_W'(side_val));
            write_register(CSR_SCALE_RATIO, CSR_DATA_W'(ratio_val));
         end

         // one or two whole images plus up to one row more, capped at 400 pixels and the items left
         count = s_eff * s_eff * $urandom_range(1, 2) + $urandom_range(0, s_eff);
         if (count > 400) count = 400;
         if (count > RANDOM_ITEMS - random_items) count = RANDOM_ITEMS - random_items;
         for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) == 0) pause_until_drained();
            feed_pixel({random_channel(), random_channel(), random_channel()});
            random_items++;
         end
      end

      // drain, then let any late transfer show up
      pause_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d pixels (%0d directed) across %0d register writes",
               pixels_sent, directed_pixels, settings_written);
      $display("checked %0d averaged pixels, %0d mismatches", averages_seen, error_count);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // hang guard, well beyond the slowest legal run
   initial begin : watchdog
      #2_000_000;
      $display("timeout with %0d averages still pending", pending_averages.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl
rtl/boxds_pkg.sv
rtl/boxds_chan_if.sv
rtl/boxds_raster.sv
rtl/boxds_accum.sv
rtl/boxds_divider.sv
rtl/box_average_downscaler.sv
sim/box_average_downscaler_test.sv
